// File: hdl/dctm_pkg.sv
// dctm_pkg: shared types and constants for the dark channel tile minimum block
// field widths, register index codes, reset values and the byte minimum helper
// no dependencies

package dctm_pkg;

    // field widths
    localparam int PIX_W   = 8;
    localparam int FW_W    = 12;
    localparam int FH_W    = 13;
    localparam int TS_W    = 7;
    localparam int PCOL_W  = 11;
    localparam int PROW_W  = 12;
    localparam int INT_W   = 6;
    localparam int CFG_I_W = 2;
    localparam int CFG_D_W = 13;

    // register index codes
    localparam logic [CFG_I_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_I_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_I_W-1:0] CFG_TILE_SIZE    = 2'd2;
    localparam logic [CFG_I_W-1:0] CFG_THREE_BAND   = 2'd3;

    // register reset values
    localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [TS_W-1:0] RST_TILE_SIZE    = 7'd5;
    localparam logic            RST_THREE_BAND   = 1'b1;
    localparam logic [PIX_W-1:0] PIX_MAX         = 8'hFF;

    // one pixel in flight between the input and result registers
    typedef struct packed {
        logic              hend;
        logic              vend;
        logic              row0;
        logic              done;
        logic [PIX_W-1:0]  run;
        logic [PROW_W-1:0] trow;
        logic [PCOL_W-1:0] tcol;
    } stage_t;

    function automatic logic [PIX_W-1:0] min8(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
        min8 = (a < b) ? a : b;
    endfunction

endpackage

// File: hdl/dark_channel_tile_min_top.sv
// dark_channel_tile_min_top: tile minimum of the per-pixel band minimum over a raster frame
// holds the counters, the per-tile-column store and the result register
// depends on dctm_pkg

// Takes one pixel per clock in raster order while no tile result is held back by
// m_tready, and gives one transfer per completed tile (tile_size square, partial at
// the right and bottom edges) carrying the tile indices and the minimum over the
// tile; tlast marks the last tile of the frame. Throughput is one pixel per cycle
// under that condition. The tile-column store is read at each input transfer and
// written as the stage of a tile's last column advances, with a bypass when the
// next pixel reads the column just written. A result is registered in the stage
// and then in the result register. The store is not cleared after reset; the first
// row of each tile row writes it. Configuration writes are taken in any cycle but
// belong only between frames or while no pixel is in flight.

module dark_channel_tile_min_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_TILE   = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // pixel input: red [7:0], green [15:8], blue [23:16]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // tile result: tile_row [11:0], tile_col [22:12], tile_min [30:23], zero [31]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [dctm_pkg::CFG_I_W-1:0] cfg_index,
    input  logic [dctm_pkg::CFG_D_W-1:0] cfg_data
);

    localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SW    = (AW > dctm_pkg::PCOL_W) ? AW : dctm_pkg::PCOL_W;
    localparam int WC0   = $clog2(MAX_WIDTH + 1);
    localparam int WCMP  = (WC0 > dctm_pkg::FW_W) ? WC0 : dctm_pkg::FW_W;
    localparam int HC0   = $clog2(MAX_HEIGHT + 1);
    localparam int HCMP  = (HC0 > dctm_pkg::FH_W) ? HC0 : dctm_pkg::FH_W;
    localparam int TC0   = $clog2(MAX_TILE + 1);
    localparam int TCMP  = (TC0 > dctm_pkg::TS_W) ? TC0 : dctm_pkg::TS_W;

    // configuration registers
    logic [dctm_pkg::FW_W-1:0] frame_width_reg;
    logic [dctm_pkg::FH_W-1:0] frame_height_reg;
    logic [dctm_pkg::TS_W-1:0] tile_size_reg;
    logic                      three_band_reg;

    // frame position state
    logic [dctm_pkg::PCOL_W-1:0] pixel_col_reg, pixel_col_next;
    logic [dctm_pkg::PROW_W-1:0] pixel_row_reg, pixel_row_next;
    logic [dctm_pkg::INT_W-1:0]  col_in_tile_reg, col_in_tile_next;
    logic [dctm_pkg::INT_W-1:0]  row_in_tile_reg, row_in_tile_next;
    logic [dctm_pkg::PCOL_W-1:0] tile_col_reg, tile_col_next;
    logic [dctm_pkg::PROW_W-1:0] tile_row_reg, tile_row_next;
    logic [dctm_pkg::PIX_W-1:0]  row_run_min_reg, row_run_min_next;

    // stage between input and result
    logic              s1_valid_reg;
    dctm_pkg::stage_t  s1_reg, s1_next;
    logic [AW-1:0]     s1_slot_reg;
    logic [dctm_pkg::PIX_W-1:0] mem_rd_reg;
    logic              fwd_sel_reg;
    logic [dctm_pkg::PIX_W-1:0] fwd_val_reg;

    // result register
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tlast_reg;

    logic [dctm_pkg::PIX_W-1:0] mem [MAX_WIDTH];

    logic [WCMP-1:0] w_lim, w_m1;
    logic [HCMP-1:0] h_lim, h_m1;
    logic [TCMP-1:0] t_lim, t_m1;
    logic [dctm_pkg::PIX_W-1:0] red, green, blue, dark;
    logic last_col, last_row, tile_h_end, tile_v_end;
    logic [SW-1:0]   slot_wide;
    logic [AW-1:0]   slot;
    logic accept, out_free, s1_result, s1_adv, store_we, fwd_hit;
    logic [dctm_pkg::PIX_W-1:0] s1_stored, s1_min;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= dctm_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= dctm_pkg::RST_FRAME_HEIGHT;
            tile_size_reg    <= dctm_pkg::RST_TILE_SIZE;
            three_band_reg   <= dctm_pkg::RST_THREE_BAND;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dctm_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[dctm_pkg::FW_W-1:0];
                dctm_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[dctm_pkg::FH_W-1:0];
                dctm_pkg::CFG_TILE_SIZE:    tile_size_reg    <= cfg_data[dctm_pkg::TS_W-1:0];
                dctm_pkg::CFG_THREE_BAND:   three_band_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped limits, zero acts as one
    always_comb
    begin
        w_lim = WCMP'(frame_width_reg);
        if (w_lim == '0)
            w_lim = WCMP'(1);
        else if (w_lim > WCMP'(MAX_WIDTH))
            w_lim = WCMP'(MAX_WIDTH);
        w_m1 = w_lim - WCMP'(1);

        h_lim = HCMP'(frame_height_reg);
        if (h_lim == '0)
            h_lim = HCMP'(1);
        else if (h_lim > HCMP'(MAX_HEIGHT))
            h_lim = HCMP'(MAX_HEIGHT);
        h_m1 = h_lim - HCMP'(1);

        t_lim = TCMP'(tile_size_reg);
        if (t_lim == '0)
            t_lim = TCMP'(1);
        else if (t_lim > TCMP'(MAX_TILE))
            t_lim = TCMP'(MAX_TILE);
        t_m1 = t_lim - TCMP'(1);
    end

    // per-pixel band minimum and tile boundaries
    assign red   = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign blue  = s_tdata[23:16];
    assign dark  = three_band_reg ? dctm_pkg::min8(red, dctm_pkg::min8(green, blue)) : red;

    assign last_col   = WCMP'(pixel_col_reg) >= w_m1;
    assign last_row   = HCMP'(pixel_row_reg) >= h_m1;
    assign tile_h_end = last_col || (TCMP'(col_in_tile_reg) >= t_m1);
    assign tile_v_end = last_row || (TCMP'(row_in_tile_reg) >= t_m1);

    assign slot_wide = SW'(tile_col_reg);
    assign slot      = slot_wide[AW-1:0];

    // handshake chain
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s1_result = s1_reg.hend && s1_reg.vend;
    assign s1_adv    = s1_valid_reg && (!s1_result || out_free);
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign accept    = s_tvalid && s_tready;
    assign store_we  = s1_adv && s1_reg.hend;
    assign fwd_hit   = store_we && (s1_slot_reg == slot);

    // tile minimum from the row run and the stored column value
    assign s1_stored = fwd_sel_reg ? fwd_val_reg : mem_rd_reg;
    assign s1_min    = s1_reg.row0 ? s1_reg.run : dctm_pkg::min8(s1_reg.run, s1_stored);

    // next frame position
    always_comb
    begin
        row_run_min_next = (col_in_tile_reg == '0) ? dark : dctm_pkg::min8(row_run_min_reg, dark);
        pixel_col_next   = pixel_col_reg;
        pixel_row_next   = pixel_row_reg;
        col_in_tile_next = col_in_tile_reg;
        row_in_tile_next = row_in_tile_reg;
        tile_col_next    = tile_col_reg;
        tile_row_next    = tile_row_reg;
        if (last_col)
        begin
            pixel_col_next   = '0;
            col_in_tile_next = '0;
            tile_col_next    = '0;
            if (last_row)
            begin
                pixel_row_next   = '0;
                row_in_tile_next = '0;
                tile_row_next    = '0;
            end
            else
            begin
                pixel_row_next = pixel_row_reg + 1'b1;
                if (tile_v_end)
                begin
                    row_in_tile_next = '0;
                    tile_row_next    = tile_row_reg + 1'b1;
                end
                else
                begin
                    row_in_tile_next = row_in_tile_reg + 1'b1;
                end
            end
        end
        else
        begin
            pixel_col_next = pixel_col_reg + 1'b1;
            if (tile_h_end)
            begin
                col_in_tile_next = '0;
                tile_col_next    = tile_col_reg + 1'b1;
            end
            else
            begin
                col_in_tile_next = col_in_tile_reg + 1'b1;
            end
        end

        s1_next.hend = tile_h_end;
        s1_next.vend = tile_v_end;
        s1_next.row0 = (row_in_tile_reg == '0);
        s1_next.done = last_col && last_row;
        s1_next.run  = row_run_min_next;
        s1_next.trow = tile_row_reg;
        s1_next.tcol = tile_col_reg;
    end

    // frame position state, updated on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_col_reg   <= '0;
            pixel_row_reg   <= '0;
            col_in_tile_reg <= '0;
            row_in_tile_reg <= '0;
            tile_col_reg    <= '0;
            tile_row_reg    <= '0;
            row_run_min_reg <= dctm_pkg::PIX_MAX;
        end
        else if (accept)
        begin
            pixel_col_reg   <= pixel_col_next;
            pixel_row_reg   <= pixel_row_next;
            col_in_tile_reg <= col_in_tile_next;
            row_in_tile_reg <= row_in_tile_next;
            tile_col_reg    <= tile_col_next;
            tile_row_reg    <= tile_row_next;
            row_run_min_reg <= row_run_min_next;
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    // stage payload and bypass of a same-column write
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg      <= s1_next;
            s1_slot_reg <= slot;
            fwd_sel_reg <= fwd_hit;
            fwd_val_reg <= s1_min;
        end
    end

    // tile-column store
    always_ff @(posedge clk)
    begin
        if (store_we)
            mem[s1_slot_reg] <= s1_min;
        if (accept)
            mem_rd_reg <= mem[slot];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_free)
            m_tvalid_reg <= s1_adv && s1_result;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_adv && s1_result)
        begin
            m_tdata_reg <= {1'b0, s1_min, s1_reg.tcol, s1_reg.trow};
            m_tlast_reg <= s1_reg.done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // an empty stage never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_tready)
        else $error("input blocked with an empty stage");

    // the last pixel of a frame always closes a tile with the frame mark
    a_frame_end_tile: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_col && last_row |=> s1_valid_reg && s1_reg.hend && s1_reg.vend
            && s1_reg.done)
        else $error("frame end pixel did not close a tile");

    // a held stage keeps its store column
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_slot_reg))
        else $error("stalled stage lost its column");

endmodule
